/* hw/rtl/lpp_pkg.sv */
package lpp_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUANT_BITS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CONTRAST    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STRETCH_LOW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STRETCH_HI  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STRETCH_RAT = 3'd6;

    // Mode register codes.
    typedef enum logic [2:0] {
        MODE_GRAY     = 3'd0,
        MODE_QUANTIZE = 3'd1,
        MODE_BRIGHT   = 3'd2,
        MODE_CONTRAST = 3'd3,
        MODE_STRETCH  = 3'd4
    } mode_t;

    // What the back end has to do with an item.
    typedef enum logic [2:0] {
        KIND_RAW,
        KIND_GRAY,
        KIND_BRIGHT,
        KIND_CONTRAST,
        KIND_STRETCH
    } kind_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [3:0]  quant_bits;
        logic [7:0]  brightness_offset;
        logic [3:0]  contrast_step;
        logic [7:0]  stretch_low;
        logic [7:0]  stretch_high;
        logic [15:0] stretch_ratio;
    } cfg_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } item_t;

    // Reset values of the registers.
    localparam logic [3:0]  QUANT_BITS_RST    = 4'd8;
    localparam logic [7:0]  STRETCH_HIGH_RST  = 8'd255;
    localparam logic [15:0] STRETCH_RATIO_RST = 16'd256;

    // Division by ten through a reciprocal: exact for dividends below 8192.
    localparam logic [12:0] DIV10_MUL   = 13'd6554;
    localparam int          DIV10_SHIFT = 16;

    // BT.601 coefficients in thousandths.
    localparam longint C_YR  = 65738;
    localparam longint C_YG  = 129057;
    localparam longint C_YB  = 25064;
    localparam longint C_UR  = -37945;
    localparam longint C_UG  = -74494;
    localparam longint C_UB  = 112439;
    localparam longint C_VR  = 112439;
    localparam longint C_VG  = -94154;
    localparam longint C_VB  = -18285;
    localparam longint C_Y   = 298082;
    localparam longint C_RV  = 408583;
    localparam longint C_GU  = -100291;
    localparam longint C_GV  = -208120;
    localparam longint C_BU  = 516411;

    // Coefficient in thousandths scaled by 2^frac, rounded half away from zero.
    function automatic longint fx_coef(input longint milli, input int frac);
        longint mag;
        longint q;
        mag = (milli < 0) ? -milli : milli;
        q   = (mag * (longint'(1) << frac) + 500) / 1000;
        return (milli < 0) ? -q : q;
    endfunction

endpackage

/* hw/rtl/lpp_cfg_regs.sv */
module lpp_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [lpp_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [lpp_pkg::CFG_DATA_W-1:0]  wr_data,
    output lpp_pkg::cfg_t                   cfg
);

    lpp_pkg::cfg_t cfg_reg;
    lpp_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                lpp_pkg::REG_MODE:        cfg_next.mode              = wr_data[2:0];
                lpp_pkg::REG_QUANT_BITS:  cfg_next.quant_bits        = wr_data[3:0];
                lpp_pkg::REG_BRIGHTNESS:  cfg_next.brightness_offset = wr_data[7:0];
                lpp_pkg::REG_CONTRAST:    cfg_next.contrast_step     = wr_data[3:0];
                lpp_pkg::REG_STRETCH_LOW: cfg_next.stretch_low       = wr_data[7:0];
                lpp_pkg::REG_STRETCH_HI:  cfg_next.stretch_high      = wr_data[7:0];
                lpp_pkg::REG_STRETCH_RAT: cfg_next.stretch_ratio     = wr_data[15:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode              <= lpp_pkg::MODE_GRAY;
            cfg_reg.quant_bits        <= lpp_pkg::QUANT_BITS_RST;
            cfg_reg.brightness_offset <= '0;
            cfg_reg.contrast_step     <= '0;
            cfg_reg.stretch_low       <= '0;
            cfg_reg.stretch_high      <= lpp_pkg::STRETCH_HIGH_RST;
            cfg_reg.stretch_ratio     <= lpp_pkg::STRETCH_RATIO_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hw/rtl/lpp_front.sv */
module lpp_front (
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           red,
    input  logic [7:0]           green,
    input  logic [7:0]           blue,
    input  lpp_pkg::cfg_t        cfg,
    input  logic                 queue_full,
    output logic                 push,
    output lpp_pkg::item_t       item
);

    logic [7:0] keep_mask;

    // Quantize keeps the top quant_bits bits of each channel.
    always_comb
    begin
        unique case (cfg.quant_bits) inside
            4'd0:          keep_mask = 8'h00;
            [4'd1:4'd7]:   keep_mask = 8'(8'hFF << (4'd8 - cfg.quant_bits));
            default:       keep_mask = 8'hFF;
        endcase
    end

    always_comb
    begin
        item.red   = red;
        item.green = green;
        item.blue  = blue;
        unique case (cfg.mode)
            lpp_pkg::MODE_GRAY:     item.kind = lpp_pkg::KIND_GRAY;
            lpp_pkg::MODE_QUANTIZE:
            begin
                item.kind  = lpp_pkg::KIND_RAW;
                item.red   = red & keep_mask;
                item.green = green & keep_mask;
                item.blue  = blue & keep_mask;
            end
            lpp_pkg::MODE_BRIGHT:   item.kind = lpp_pkg::KIND_BRIGHT;
            lpp_pkg::MODE_CONTRAST: item.kind = lpp_pkg::KIND_CONTRAST;
            lpp_pkg::MODE_STRETCH:  item.kind = lpp_pkg::KIND_STRETCH;
            default:                item.kind = lpp_pkg::KIND_RAW;
        endcase
    end

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

endmodule

/* hw/rtl/lpp_queue.sv */
module lpp_queue #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lpp_pkg::item_t  push_item,
    output logic            full,
    output logic            pop_valid,
    input  logic            pop_ready,
    output lpp_pkg::item_t  pop_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    lpp_pkg::item_t mem [DEPTH];

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;

    assign pop       = pop_valid && pop_ready;
    assign pop_valid = (count_reg != '0);
    assign full      = (count_reg == CW'(DEPTH));
    assign pop_item  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* hw/rtl/lpp_back.sv */
module lpp_back #(
    parameter int COEF_FRAC_BITS = 10
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  lpp_pkg::item_t  in_item,
    input  lpp_pkg::cfg_t   cfg,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      red_out,
    output logic [7:0]      green_out,
    output logic [7:0]      blue_out
);

    localparam int KW = COEF_FRAC_BITS + 11;
    localparam int PW = KW + 9;
    localparam int SW = PW + 2;
    localparam int SH = 8 + COEF_FRAC_BITS;

    localparam logic signed [KW-1:0] K_YR = KW'(lpp_pkg::fx_coef(lpp_pkg::C_YR, COEF_FRAC_BITS));
    localparam logic signed [KW-1:0] K_YG = KW'(lpp_pkg::fx_coef(lpp_pkg::C_YG, COEF_FRAC_BITS));
    localparam logic signed [KW-1:0] K_YB = KW'(lpp_pkg::fx_coef(lpp_pkg::C_YB, COEF_FRAC_BITS));
    localparam logic signed [KW-1:0] K_UR = KW'(lpp_pkg::fx_coef(lpp_pkg::C_UR, COEF_FRAC_BITS));
    localparam logic signed [KW-1:0] K_UG = KW'(lpp_pkg::fx_coef(lpp_pkg::C_UG, COEF_FRAC_BITS));
    localparam logic signed [KW-1:0] K_UB = KW'(lpp_pkg::fx_coef(lpp_pkg::C_UB, COEF_FRAC_BITS));
    localparam logic signed [KW-1:0] K_VR = KW'(lpp_pkg::fx_coef(lpp_pkg::C_VR, COEF_FRAC_BITS));
    localparam logic signed [KW-1:0] K_VG = KW'(lpp_pkg::fx_coef(lpp_pkg::C_VG, COEF_FRAC_BITS));
    localparam logic signed [KW-1:0] K_VB = KW'(lpp_pkg::fx_coef(lpp_pkg::C_VB, COEF_FRAC_BITS));
    localparam logic signed [KW-1:0] K_Y  = KW'(lpp_pkg::fx_coef(lpp_pkg::C_Y, COEF_FRAC_BITS));
    localparam logic signed [KW-1:0] K_RV = KW'(lpp_pkg::fx_coef(lpp_pkg::C_RV, COEF_FRAC_BITS));
    localparam logic signed [KW-1:0] K_GU = KW'(lpp_pkg::fx_coef(lpp_pkg::C_GU, COEF_FRAC_BITS));
    localparam logic signed [KW-1:0] K_GV = KW'(lpp_pkg::fx_coef(lpp_pkg::C_GV, COEF_FRAC_BITS));
    localparam logic signed [KW-1:0] K_BU = KW'(lpp_pkg::fx_coef(lpp_pkg::C_BU, COEF_FRAC_BITS));

    localparam logic signed [SW-1:0] DIV_BIAS = {{(SW - SH){1'b0}}, {SH{1'b1}}};
    localparam logic signed [SW-1:0] MAX8     = SW'(255);

    // Divide by 2^SH with truncation toward zero.
    function automatic logic signed [SW-1:0] trunc_div(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] bias;
        bias = v[SW-1] ? DIV_BIAS : '0;
        return (v + bias) >>> SH;
    endfunction

    function automatic logic [7:0] clamp8(input logic signed [SW-1:0] v);
        logic [7:0] r;
        if (v[SW-1])
        begin
            r = 8'd0;
        end
        else if (v > MAX8)
        begin
            r = 8'd255;
        end
        else
        begin
            r = v[7:0];
        end
        return r;
    endfunction

    // The whole pipeline advances together unless the output register is held.
    logic advance;
    assign advance  = !out_valid || out_ready;
    assign in_ready = advance;

    // Stage valid bits.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;

    // Kind and carried pixel per stage.
    lpp_pkg::kind_t kind1_reg, kind2_reg, kind3_reg, kind4_reg, kind5_reg;
    logic [23:0]    pix1_reg, pix2_reg, pix3_reg, pix4_reg, pix5_reg;
    logic [23:0]    pix3_next;

    // Stage 1: forward products.
    logic signed [8:0]    r_s, g_s, b_s;
    logic signed [PW-1:0] p_yr_reg, p_yg_reg, p_yb_reg;
    logic signed [PW-1:0] p_ur_reg, p_ug_reg, p_ub_reg;
    logic signed [PW-1:0] p_vr_reg, p_vg_reg, p_vb_reg;
    logic signed [PW-1:0] p_yr_next, p_yg_next, p_yb_next;
    logic signed [PW-1:0] p_ur_next, p_ug_next, p_ub_next;
    logic signed [PW-1:0] p_vr_next, p_vg_next, p_vb_next;

    assign r_s = $signed({1'b0, in_item.red});
    assign g_s = $signed({1'b0, in_item.green});
    assign b_s = $signed({1'b0, in_item.blue});

    assign p_yr_next = K_YR * r_s;
    assign p_yg_next = K_YG * g_s;
    assign p_yb_next = K_YB * b_s;
    assign p_ur_next = K_UR * r_s;
    assign p_ug_next = K_UG * g_s;
    assign p_ub_next = K_UB * b_s;
    assign p_vr_next = K_VR * r_s;
    assign p_vg_next = K_VG * g_s;
    assign p_vb_next = K_VB * b_s;

    // Stage 2: luma and chroma offsets u = Cb - 128, v = Cr - 128.
    logic signed [SW-1:0] q_y, q_u, q_v;
    logic [7:0]           y2_reg, y2_next;
    logic signed [8:0]    u2_reg, v2c_reg, u2_next, v2c_next;

    assign q_y = trunc_div(SW'(p_yr_reg) + SW'(p_yg_reg) + SW'(p_yb_reg));
    assign q_u = trunc_div(SW'(p_ur_reg) + SW'(p_ug_reg) + SW'(p_ub_reg));
    assign q_v = trunc_div(SW'(p_vr_reg) + SW'(p_vg_reg) + SW'(p_vb_reg));

    assign y2_next  = q_y[7:0] + 8'd16;
    assign u2_next  = q_u[8:0];
    assign v2c_next = q_v[8:0];

    // Stage 3: luma change, first step (sum or product).
    logic [8:0]        bright_sum;
    logic [12:0]       contrast_prod;
    logic [7:0]        stretch_diff;
    logic [23:0]       stretch_prod;
    logic [23:0]       ym3_reg, ym3_next;
    logic              le_low3_reg, ge_high3_reg;
    logic              le_low3_next, ge_high3_next;
    logic signed [8:0] u3_reg, v3c_reg;

    assign bright_sum    = {1'b0, y2_reg} + {1'b0, cfg.brightness_offset};
    assign contrast_prod = 13'(y2_reg) * 13'(5'd10 + {1'b0, cfg.contrast_step});
    assign stretch_diff  = y2_reg - cfg.stretch_low;
    assign stretch_prod  = 24'(stretch_diff) * 24'(cfg.stretch_ratio);
    assign le_low3_next  = (y2_reg <= cfg.stretch_low);
    assign ge_high3_next = (y2_reg >= cfg.stretch_high);

    always_comb
    begin
        case (kind2_reg)
            lpp_pkg::KIND_BRIGHT:   ym3_next = 24'(bright_sum);
            lpp_pkg::KIND_CONTRAST: ym3_next = 24'(contrast_prod);
            lpp_pkg::KIND_STRETCH:  ym3_next = stretch_prod;
            default:                ym3_next = '0;
        endcase
    end

    // Gray items take their luma on all channels here and ride to the end.
    assign pix3_next = (kind2_reg == lpp_pkg::KIND_GRAY) ? {y2_reg, y2_reg, y2_reg} : pix2_reg;

    // Stage 4: luma change, final step with saturation.
    logic [25:0]       div10_prod;
    logic [9:0]        div10_quot;
    logic [7:0]        yn4_reg, yn4_next;
    logic signed [8:0] u4_reg, v4c_reg;

    assign div10_prod = 26'(ym3_reg[12:0]) * 26'(lpp_pkg::DIV10_MUL);
    assign div10_quot = div10_prod[lpp_pkg::DIV10_SHIFT +: 10];

    always_comb
    begin
        case (kind3_reg)
            lpp_pkg::KIND_BRIGHT:
                yn4_next = ym3_reg[8] ? 8'd255 : ym3_reg[7:0];
            lpp_pkg::KIND_CONTRAST:
                yn4_next = (div10_quot[9:8] != 2'b00) ? 8'd255 : div10_quot[7:0];
            lpp_pkg::KIND_STRETCH:
            begin
                if (le_low3_reg)
                begin
                    yn4_next = 8'd0;
                end
                else if (ge_high3_reg || (ym3_reg[23:16] != 8'd0))
                begin
                    yn4_next = 8'd255;
                end
                else
                begin
                    yn4_next = ym3_reg[15:8];
                end
            end
            default:
                yn4_next = 8'd0;
        endcase
    end

    // Stage 5: inverse products.
    logic signed [8:0]    ys4;
    logic signed [PW-1:0] p_y_reg, p_rv_reg, p_gu_reg, p_gv_reg, p_bu_reg;
    logic signed [PW-1:0] p_y_next, p_rv_next, p_gu_next, p_gv_next, p_bu_next;

    assign ys4       = $signed({1'b0, yn4_reg}) - 9'sd16;
    assign p_y_next  = K_Y * ys4;
    assign p_rv_next = K_RV * v4c_reg;
    assign p_gu_next = K_GU * u4_reg;
    assign p_gv_next = K_GV * v4c_reg;
    assign p_bu_next = K_BU * u4_reg;

    // Stage 6: sums, division, clamp and output selection.
    logic [7:0]  conv_r, conv_g, conv_b;
    logic [23:0] pix6_reg, pix6_next;

    assign conv_r = clamp8(trunc_div(SW'(p_y_reg) + SW'(p_rv_reg)));
    assign conv_g = clamp8(trunc_div(SW'(p_y_reg) + SW'(p_gu_reg) + SW'(p_gv_reg)));
    assign conv_b = clamp8(trunc_div(SW'(p_y_reg) + SW'(p_bu_reg)));

    always_comb
    begin
        case (kind5_reg) inside
            lpp_pkg::KIND_BRIGHT,
            lpp_pkg::KIND_CONTRAST,
            lpp_pkg::KIND_STRETCH: pix6_next = {conv_b, conv_g, conv_r};
            default:               pix6_next = pix5_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            kind1_reg <= in_item.kind;
            pix1_reg  <= {in_item.blue, in_item.green, in_item.red};
            p_yr_reg  <= p_yr_next;
            p_yg_reg  <= p_yg_next;
            p_yb_reg  <= p_yb_next;
            p_ur_reg  <= p_ur_next;
            p_ug_reg  <= p_ug_next;
            p_ub_reg  <= p_ub_next;
            p_vr_reg  <= p_vr_next;
            p_vg_reg  <= p_vg_next;
            p_vb_reg  <= p_vb_next;

            kind2_reg <= kind1_reg;
            pix2_reg  <= pix1_reg;
            y2_reg    <= y2_next;
            u2_reg    <= u2_next;
            v2c_reg   <= v2c_next;

            kind3_reg    <= kind2_reg;
            pix3_reg     <= pix3_next;
            ym3_reg      <= ym3_next;
            le_low3_reg  <= le_low3_next;
            ge_high3_reg <= ge_high3_next;
            u3_reg       <= u2_reg;
            v3c_reg      <= v2c_reg;

            kind4_reg <= kind3_reg;
            pix4_reg  <= pix3_reg;
            yn4_reg   <= yn4_next;
            u4_reg    <= u3_reg;
            v4c_reg   <= v3c_reg;

            kind5_reg <= kind4_reg;
            pix5_reg  <= pix4_reg;
            p_y_reg   <= p_y_next;
            p_rv_reg  <= p_rv_next;
            p_gu_reg  <= p_gu_next;
            p_gv_reg  <= p_gv_next;
            p_bu_reg  <= p_bu_next;

            pix6_reg  <= pix6_next;
        end
    end

    assign out_valid = v6_reg;
    assign red_out   = pix6_reg[7:0];
    assign green_out = pix6_reg[15:8];
    assign blue_out  = pix6_reg[23:16];

endmodule

/* hw/rtl/luma_point_processor_top.sv */
// Per-pixel point operation on an 8-bit RGB stream, chosen by the mode register:
// gray (BT.601 luma on all channels), quantize, or a brightness, contrast or
// stretch change of Y done in the YCbCr domain and converted back to RGB; unused mode codes pass the pixel through.
// The block takes one pixel per clock unless its queue is full and delivers
// one result per pixel, in order. The rate is set by the six-stage back-end
// pipeline, which moves as a whole whenever its output register is empty or
// is being taken. A short queue in front of it keeps s_tready high while the
// output side stalls, until the queue fills. Configuration writes are always
// accepted (cfg_ready is tied high) and must only be issued while no pixel
// is in flight.
module luma_point_processor_top #(
    parameter int COEF_FRAC_BITS = 10,
    parameter int QUEUE_DEPTH    = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,

    // Pixel input stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata fields from bit 0: red_in[7:0], green_in[15:8], blue_in[23:16].
    input  logic [23:0]                     s_tdata,

    // Pixel output stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata fields from bit 0: red_out[7:0], green_out[15:8], blue_out[23:16].
    output logic [23:0]                     m_tdata,

    // Register write channel.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lpp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lpp_pkg::CFG_DATA_W-1:0]  cfg_data
);

    lpp_pkg::cfg_t  cfg;
    lpp_pkg::item_t front_item;
    lpp_pkg::item_t queue_item;
    logic           push;
    logic           queue_full;
    logic           queue_valid;
    logic           back_ready;

    // The register file never stalls a write.
    assign cfg_ready = 1'b1;

    lpp_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // The front end decodes the mode for each pixel and applies quantize and
    // pass-through right away, so the back end sees an item kind rather than the mode.
    lpp_front u_front (
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .red        (s_tdata[7:0]),
        .green      (s_tdata[15:8]),
        .blue       (s_tdata[23:16]),
        .cfg        (cfg),
        .queue_full (queue_full),
        .push       (push),
        .item       (front_item)
    );

    lpp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .full      (queue_full),
        .pop_valid (queue_valid),
        .pop_ready (back_ready),
        .pop_item  (queue_item)
    );

    // The back end holds the color conversion pipeline and the output register.
    lpp_back #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (queue_valid),
        .in_ready  (back_ready),
        .in_item   (queue_item),
        .cfg       (cfg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .red_out   (m_tdata[7:0]),
        .green_out (m_tdata[15:8]),
        .blue_out  (m_tdata[23:16])
    );

endmodule

/* tb/sv/tb.sv */
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int          RANDOM_PIXELS = 950;

    // Index one past the register list: writes to it must change nothing.
    localparam logic [lpp_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    // Mode codes with no operation behind them: the pixel passes through.
    localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

    // Red sits in the low byte, as on both stream buses.
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [23:0]                    s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [23:0]                    m_tdata;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [lpp_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [lpp_pkg::CFG_DATA_W-1:0] cfg_data;

    bit send_idles = 1'b1;
    bit take_idles = 1'b1;
    int unsigned cycles = 0;

    // Holds a copy of the registers, predicts each accepted pixel and keeps the
    // predictions in order until the matching output transfer arrives.
    class pixel_scoreboard;
        localparam int FRAC_BITS = 10;
        localparam int SUM_SHIFT = 8 + FRAC_BITS;

        logic [2:0]  op_mode;
        logic [3:0]  quant_bits;
        logic [7:0]  brightness_offset;
        logic [3:0]  contrast_step;
        logic [7:0]  stretch_low;
        logic [7:0]  stretch_high;
        logic [15:0] stretch_ratio;
        rgb_t        expected_pixels[$];
        int          failures;

        function new();
            op_mode           = lpp_pkg::MODE_GRAY;
            quant_bits        = lpp_pkg::QUANT_BITS_RST;
            brightness_offset = 8'd0;
            contrast_step     = 4'd0;
            stretch_low       = 8'd0;
            stretch_high      = lpp_pkg::STRETCH_HIGH_RST;
            stretch_ratio     = lpp_pkg::STRETCH_RATIO_RST;
            failures          = 0;
        endfunction

        function void write_reg(logic [lpp_pkg::CFG_IDX_W-1:0] idx,
                                logic [lpp_pkg::CFG_DATA_W-1:0] value);
            case (idx)
                lpp_pkg::REG_MODE:        op_mode           = value[2:0];
                lpp_pkg::REG_QUANT_BITS:  quant_bits        = value[3:0];
                lpp_pkg::REG_BRIGHTNESS:  brightness_offset = value[7:0];
                lpp_pkg::REG_CONTRAST:    contrast_step     = value[3:0];
                lpp_pkg::REG_STRETCH_LOW: stretch_low       = value[7:0];
                lpp_pkg::REG_STRETCH_HI:  stretch_high      = value[7:0];
                lpp_pkg::REG_STRETCH_RAT: stretch_ratio     = value;
                default: ;
            endcase
        endfunction

        // Coefficient given in thousandths, scaled by 2^FRAC_BITS and rounded
        // half away from zero.
        function longint scaled_coef(longint milli);
            longint mag;
            mag = (milli < 0) ? -milli : milli;
            mag = (mag * (longint'(1) << FRAC_BITS) + 500) / 1000;
            return (milli < 0) ? -mag : mag;
        endfunction

        // Drops the scale of a dot product, truncating toward zero.
        function longint unscale(longint v);
            if (v < 0)
            begin
                return -((-v) >>> SUM_SHIFT);
            end
            return v >>> SUM_SHIFT;
        endfunction

        function logic [7:0] clamp_byte(longint v);
            if (v < 0)
            begin
                return 8'd0;
            end
            if (v > 255)
            begin
                return 8'd255;
            end
            return v[7:0];
        endfunction

        function longint luma(longint r, longint g, longint b);
            return 16 + unscale(scaled_coef(65738) * r + scaled_coef(129057) * g
                                + scaled_coef(25064) * b);
        endfunction

        function rgb_t predict_pixel(rgb_t px);
            longint r, g, b, y, cb, cr, yn, yc, u, v;
            longint lo, hi, ratio, gain;
            logic [7:0] keep;
            rgb_t res;
            r = px.red;
            g = px.green;
            b = px.blue;
            if (op_mode == lpp_pkg::MODE_GRAY)
            begin
                res.red   = clamp_byte(luma(r, g, b));
                res.green = res.red;
                res.blue  = res.red;
                return res;
            end
            if (op_mode == lpp_pkg::MODE_QUANTIZE)
            begin
                keep = 8'hFF;
                if (quant_bits == 4'd0)
                begin
                    keep = 8'h00;
                end
                else if (quant_bits < 4'd8)
                begin
                    keep = 8'hFF << (8 - int'(quant_bits));
                end
                res.red   = px.red & keep;
                res.green = px.green & keep;
                res.blue  = px.blue & keep;
                return res;
            end
            if (op_mode > lpp_pkg::MODE_STRETCH)
            begin
                return px;
            end

            // The remaining modes change Y in the YCbCr domain only.
            y  = luma(r, g, b);
            cb = 128 + unscale(scaled_coef(-37945) * r + scaled_coef(-74494) * g
                               + scaled_coef(112439) * b);
            cr = 128 + unscale(scaled_coef(112439) * r + scaled_coef(-94154) * g
                               + scaled_coef(-18285) * b);
            lo    = stretch_low;
            hi    = stretch_high;
            ratio = stretch_ratio;
            gain  = contrast_step;
            if (op_mode == lpp_pkg::MODE_BRIGHT)
            begin
                yn = y + longint'(brightness_offset);
            end
            else if (op_mode == lpp_pkg::MODE_CONTRAST)
            begin
                yn = (y * (10 + gain)) / 10;
            end
            else if (y <= lo)
            begin
                yn = 0;
            end
            else if (y >= hi)
            begin
                yn = 255;
            end
            else
            begin
                yn = ((y - lo) * ratio) >>> 8;
            end
            if (yn > 255)
            begin
                yn = 255;
            end

            yc = scaled_coef(298082) * (yn - 16);
            u  = cb - 128;
            v  = cr - 128;
            res.red   = clamp_byte(unscale(yc + scaled_coef(408583) * v));
            res.green = clamp_byte(unscale(yc + scaled_coef(-100291) * u
                                           + scaled_coef(-208120) * v));
            res.blue  = clamp_byte(unscale(yc + scaled_coef(516411) * u));
            return res;
        endfunction

        function void note_pixel(rgb_t px);
            expected_pixels.push_back(predict_pixel(px));
        endfunction

        function void check_pixel(rgb_t got);
            rgb_t want;
            if (expected_pixels.size() == 0)
            begin
                $error("output transfer %h with no pixel outstanding", got);
                failures++;
                return;
            end
            want = expected_pixels.pop_front();
            if (got.red !== want.red)
            begin
                $error("red_out: expected %0d, actual %0d", want.red, got.red);
                failures++;
            end
            if (got.green !== want.green)
            begin
                $error("green_out: expected %0d, actual %0d", want.green, got.green);
                failures++;
            end
            if (got.blue !== want.blue)
            begin
                $error("blue_out: expected %0d, actual %0d", want.blue, got.blue);
                failures++;
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    pixel_scoreboard scoreboard;

    luma_point_processor_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Output side: stall at random, or take every transfer while idling is off.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= !(take_idles && $urandom_range(0, 99) < 31);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            scoreboard.check_pixel(rgb_t'(m_tdata));
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[luma_point_processor_top] ERROR");
            $finish;
        end
    end

    function automatic rgb_t make_rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        rgb_t px;
        px.red   = r;
        px.green = g;
        px.blue  = b;
        return px;
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 3))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic rgb_t random_pixel();
        logic [7:0] level;
        case ($urandom_range(0, 7))
            0:
            begin
                return make_rgb({8{$urandom_range(0, 1) == 1}}, {8{$urandom_range(0, 1) == 1}},
                                {8{$urandom_range(0, 1) == 1}});
            end
            1:
            begin
                level = 8'($urandom_range(0, 255));
                return make_rgb(level, level, level);
            end
            default: return rgb_t'(24'($urandom));
        endcase
    endfunction

    // Half of the time, garbage goes into the data bits above the register.
    function automatic logic [15:0] with_junk(logic [15:0] value, int width);
        logic [15:0] mask;
        mask = (width >= 16) ? 16'hFFFF : ((16'd1 << width) - 16'd1);
        if ($urandom_range(0, 1) == 0)
        begin
            return value & mask;
        end
        return (value & mask) | (16'($urandom) & ~mask);
    endfunction

    // Leaves cfg_valid high; the next pixel transfer lowers it, so back-to-back
    // writes never drop and raise it within one step.
    task automatic set_reg(logic [lpp_pkg::CFG_IDX_W-1:0] idx,
                           logic [lpp_pkg::CFG_DATA_W-1:0] value);
        s_tvalid <= 1'b0;
        while (scoreboard.pending() != 0)
        begin
            @(negedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        scoreboard.write_reg(idx, value);
        @(negedge clk);
    endtask

    task automatic send_pixel(rgb_t px);
        cfg_valid <= 1'b0;
        while (send_idles && $urandom_range(0, 99) < 31)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge clk); while (!s_tready);
        scoreboard.note_pixel(px);
        @(negedge clk);
    endtask

    task automatic random_setting();
        logic [2:0]  m;
        logic [7:0]  lo, hi, t;
        logic [15:0] rat;
        if ($urandom_range(0, 9) == 0)
        begin
            m = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
        end
        else
        begin
            m = 3'($urandom_range(lpp_pkg::MODE_GRAY, lpp_pkg::MODE_STRETCH));
        end
        lo = pick_byte();
        hi = pick_byte();
        if ($urandom_range(0, 4) != 0 && lo > hi)
        begin
            t  = lo;
            lo = hi;
            hi = t;
        end
        // Half of the time the slope that maps the window onto the full range, as intended.
        case ($urandom_range(0, 3))
            0:       rat = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
            1, 2:    rat = (hi > lo) ? 16'(65280 / (hi - lo)) : lpp_pkg::STRETCH_RATIO_RST;
            default: rat = 16'($urandom);
        endcase
        set_reg(lpp_pkg::REG_MODE, with_junk(16'(m), 3));
        set_reg(lpp_pkg::REG_QUANT_BITS, with_junk(16'($urandom_range(0, 15)), 4));
        set_reg(lpp_pkg::REG_BRIGHTNESS, with_junk(16'(pick_byte()), 8));
        set_reg(lpp_pkg::REG_CONTRAST, with_junk(16'($urandom_range(0, 15)), 4));
        set_reg(lpp_pkg::REG_STRETCH_LOW, with_junk(16'(lo), 8));
        set_reg(lpp_pkg::REG_STRETCH_HI, with_junk(16'(hi), 8));
        set_reg(lpp_pkg::REG_STRETCH_RAT, rat);
        if ($urandom_range(0, 3) == 0)
        begin
            set_reg(REG_SPARE, 16'($urandom));
        end
    endtask

    initial
    begin
        int unsigned sent;
        int unsigned phase;
        int unsigned burst;
        logic [2:0]  m;

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        scoreboard = new();
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Register values after reset, one mode at a time.
        send_pixel(make_rgb(8'd255, 8'd255, 8'd255));
        send_pixel(make_rgb(8'd0, 8'd0, 8'd0));
        send_pixel(make_rgb(8'd255, 8'd0, 8'd0));
        set_reg(lpp_pkg::REG_MODE, 16'(lpp_pkg::MODE_QUANTIZE));
        send_pixel(make_rgb(8'hA5, 8'h5A, 8'h3C));
        set_reg(lpp_pkg::REG_MODE, 16'(lpp_pkg::MODE_BRIGHT));
        send_pixel(make_rgb(8'd0, 8'd255, 8'd0));
        set_reg(lpp_pkg::REG_MODE, 16'(lpp_pkg::MODE_CONTRAST));
        send_pixel(make_rgb(8'd0, 8'd0, 8'd255));
        set_reg(lpp_pkg::REG_MODE, 16'(lpp_pkg::MODE_STRETCH));
        send_pixel(make_rgb(8'd128, 8'd64, 8'd200));

        // Quantize with nothing kept, one bit kept, and a count beyond eight.
        set_reg(lpp_pkg::REG_MODE, 16'(lpp_pkg::MODE_QUANTIZE));
        set_reg(lpp_pkg::REG_QUANT_BITS, 16'd0);
        send_pixel(make_rgb(8'd255, 8'd255, 8'd255));
        set_reg(lpp_pkg::REG_QUANT_BITS, 16'd1);
        send_pixel(make_rgb(8'd255, 8'd128, 8'd127));
        set_reg(lpp_pkg::REG_QUANT_BITS, 16'd15);
        send_pixel(make_rgb(8'h81, 8'h42, 8'h18));

        // Brightness saturating at the top.
        set_reg(lpp_pkg::REG_MODE, 16'(lpp_pkg::MODE_BRIGHT));
        set_reg(lpp_pkg::REG_BRIGHTNESS, 16'd255);
        send_pixel(make_rgb(8'd255, 8'd255, 8'd255));
        send_pixel(make_rgb(8'd0, 8'd0, 8'd255));

        // Contrast gain above the nominal range, then at its top.
        set_reg(lpp_pkg::REG_MODE, 16'(lpp_pkg::MODE_CONTRAST));
        set_reg(lpp_pkg::REG_CONTRAST, 16'd15);
        send_pixel(make_rgb(8'd255, 8'd255, 8'd255));
        send_pixel(make_rgb(8'd128, 8'd128, 8'd128));
        set_reg(lpp_pkg::REG_CONTRAST, 16'd10);
        send_pixel(make_rgb(8'd90, 8'd200, 8'd30));

        // Stretch with the bounds crossed, then a slope far too steep.
        set_reg(lpp_pkg::REG_MODE, 16'(lpp_pkg::MODE_STRETCH));
        set_reg(lpp_pkg::REG_STRETCH_LOW, 16'd200);
        set_reg(lpp_pkg::REG_STRETCH_HI, 16'd100);
        send_pixel(make_rgb(8'd0, 8'd0, 8'd0));
        send_pixel(make_rgb(8'd255, 8'd255, 8'd255));
        set_reg(lpp_pkg::REG_STRETCH_LOW, 16'd0);
        set_reg(lpp_pkg::REG_STRETCH_HI, 16'd255);
        set_reg(lpp_pkg::REG_STRETCH_RAT, 16'hFFFF);
        send_pixel(make_rgb(8'd100, 8'd100, 8'd100));

        // Unused mode codes pass the pixel through; a write past the last
        // register must leave the setup alone.
        for (m = MODE_SPARE_FIRST; ; m++)
        begin
            set_reg(lpp_pkg::REG_MODE, 16'(m));
            send_pixel(make_rgb(8'd17 * m, 8'd255 - m, 8'd3 << m));
            if (m == MODE_SPARE_LAST)
            begin
                break;
            end
        end
        set_reg(REG_SPARE, 16'hFFFF);
        send_pixel(make_rgb(8'd12, 8'd34, 8'd56));

        // Random setups, each followed by a burst of random pixels. One burst
        // runs with both sides at full rate.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_PIXELS)
        begin
            random_setting();
            if (phase == 3)
            begin
                burst      = 200;
                send_idles = 1'b0;
                take_idles <= 1'b0;
            end
            else
            begin
                burst = $urandom_range(20, 90);
            end
            repeat (burst)
            begin
                send_pixel(random_pixel());
            end
            send_idles = 1'b1;
            take_idles <= 1'b1;
            sent += burst;
            phase++;
        end

        // Let the pipeline and its queue empty, then watch for stray transfers.
        s_tvalid <= 1'b0;
        while (scoreboard.pending() != 0)
        begin
            @(negedge clk);
        end
        repeat (16) @(negedge clk);
        if (scoreboard.failures == 0)
        begin
            $display("[luma_point_processor_top] OK");
        end
        else
        begin
            $display("[luma_point_processor_top] ERROR");
        end
        $finish;
    end

endmodule
